>>> sv/tidst_pkg.sv
`default_nettype none

package tidst_pkg;

    // default number of contact slots
    localparam int SLOT_COUNT_DEF = 16;

    // field widths
    localparam int ID_W   = 32;
    localparam int POS_W  = 16;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 3;
    localparam int OP_W   = 2;

    // touch actions
    localparam logic [OP_W-1:0] OP_DOWN   = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_UP     = 2'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

    // point status codes
    localparam logic [STAT_W-1:0] ST_PLACED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // input beat
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ID_W-1:0]  contact_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             frame_last;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [STAT_W-1:0] point_status;
        logic [POS_W-1:0]  out_x;
        logic [POS_W-1:0]  out_y;
        logic              frame_end;
        logic              frame_empty;
    } t_out_beat;

    // slot table decision for one point
    typedef struct packed {
        logic              accepted;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_index;
    } t_slot_resp;

endpackage

`default_nettype wire

>>> sv/tidst_slot_table.sv
`default_nettype none

module tidst_slot_table #(
    parameter int SLOT_COUNT = tidst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [tidst_pkg::OP_W-1:0]  i_op,
    input  wire logic [tidst_pkg::ID_W-1:0]  i_id,
    output tidst_pkg::t_slot_resp            o_resp
);
    import tidst_pkg::*;

    localparam int SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [SLOT_COUNT-1:0] r_busy;
    logic [SLOT_COUNT-1:0] n_busy;
    logic [ID_W-1:0]       r_owner [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] w_match;
    logic                  w_hit;
    logic [SIW-1:0]        w_hit_idx;
    logic                  w_free;
    logic [SIW-1:0]        w_free_idx;
    logic                  w_release;
    logic                  w_place;
    logic [SIW-1:0]        w_idx;
    logic [SIW+SLOT_W-1:0] w_idx_ext;

    // parallel id compare against every busy slot
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            w_match[s] = r_busy[s] && (r_owner[s] == i_id);
        end
    end

    // lowest matching slot and lowest free slot
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (w_match[s]) begin
                w_hit     = 1'b1;
                w_hit_idx = SIW'(s);
            end
            if (!r_busy[s]) begin
                w_free     = 1'b1;
                w_free_idx = SIW'(s);
            end
        end
    end

    // decide what happens to the point
    always_comb begin
        w_release       = 1'b0;
        w_place         = 1'b0;
        w_idx           = '0;
        o_resp.accepted = 1'b0;
        o_resp.status   = ST_UNKNOWN;
        if (w_hit) begin
            o_resp.accepted = 1'b1;
            w_idx           = w_hit_idx;
            if ((i_op == OP_UP) || (i_op == OP_CANCEL)) begin
                w_release     = 1'b1;
                o_resp.status = ST_RELEASED;
            end else begin
                o_resp.status = ST_UPDATED;
            end
        end else if (i_op != OP_DOWN) begin
            o_resp.status = ST_UNKNOWN;
        end else if (w_free) begin
            w_place         = 1'b1;
            w_idx           = w_free_idx;
            o_resp.accepted = 1'b1;
            o_resp.status   = ST_PLACED;
        end else begin
            o_resp.status = ST_FULL;
        end
    end

    // slot number carries its low bits into the field
    assign w_idx_ext         = {{SLOT_W{1'b0}}, w_idx};
    assign o_resp.slot_index = w_idx_ext[SLOT_W-1:0];

    // busy bitmap update
    always_comb begin
        n_busy = r_busy;
        if (i_en && w_release) begin
            n_busy[w_hit_idx] = 1'b0;
        end
        if (i_en && w_place) begin
            n_busy[w_free_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // owner id written when a slot is taken
    always_ff @(posedge i_clk) begin
        if (i_en && w_place) begin
            r_owner[w_free_idx] <= i_id;
        end
    end

endmodule

`default_nettype wire

>>> sv/touch_id_slot_tracker.sv
// a point is held in the input register, then its result beat in the result register
// throughput: one point per cycle unless i_out_ready holds the result stage; the slot lookup,
//   free-slot search and bitmap update are combinational between input and result registers
// reset: synchronous, active low; all slots free, frame flag cleared,
//   both register stages empty
`default_nettype none

module touch_id_slot_tracker #(
    parameter int SLOT_COUNT = tidst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tidst_pkg::t_in_beat i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tidst_pkg::t_out_beat o_out_data
);
    import tidst_pkg::*;

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;
    logic       r_frame_acc;
    logic       n_frame_acc;

    logic       w_adv;
    logic       w_fire;
    t_slot_resp w_resp;
    t_out_beat  n_out;

    // handshake: result stage frees up when empty or being taken
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    // slot bookkeeping
    tidst_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_op    (r_in.opcode),
        .i_id    (r_in.contact_id),
        .o_resp  (w_resp)
    );

    // result beat assembly and frame flag
    always_comb begin
        n_out.slot_index   = w_resp.slot_index;
        n_out.point_status = w_resp.status;
        n_out.out_x        = w_resp.accepted ? r_in.pos_x : '0;
        n_out.out_y        = w_resp.accepted ? r_in.pos_y : '0;
        n_out.frame_end    = r_in.frame_last;
        n_out.frame_empty  = r_in.frame_last && !(r_frame_acc || w_resp.accepted);
        n_frame_acc        = r_frame_acc;
        if (w_fire) begin
            n_frame_acc = r_in.frame_last ? 1'b0 : (r_frame_acc || w_resp.accepted);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_frame_acc <= 1'b0;
        end else begin
            r_frame_acc <= n_frame_acc;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tidst_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int RAND_POINTS = 500;
    localparam int PHASES      = 3;
    localparam int SWING_LEN   = 40;

    // expected slot table behaviour and queue of predicted result beats
    class point_scoreboard;
        logic [SLOTS-1:0] busy;
        logic [ID_W-1:0]  owner [SLOTS];
        bit               frame_hit;
        t_out_beat        due [$];
        int               errors;
        int               results;
        int               frames;
        int               empty_frames;
        int               by_status [2**STAT_W];

        function new();
            busy = '0;
            frame_hit = 1'b0;
            errors = 0;
            results = 0;
            frames = 0;
            empty_frames = 0;
            foreach (owner[s]) owner[s] = '0;
            foreach (by_status[k]) by_status[k] = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string what);
            if (errors < 50) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
            errors++;
        endtask

        // predict the result beat for one accepted touch point
        function void note(t_in_beat b);
            int        hit;
            bit        taken;
            t_out_beat r;
            hit = -1;
            taken = 1'b0;
            r = '0;
            for (int s = 0; s < SLOTS; s++) begin
                if (hit < 0 && busy[s] && owner[s] == b.contact_id) hit = s;
            end
            if (hit >= 0) begin
                taken = 1'b1;
                if (b.opcode == OP_UP || b.opcode == OP_CANCEL) begin
                    busy[hit] = 1'b0;
                    r.point_status = ST_RELEASED;
                end else begin
                    r.point_status = ST_UPDATED;
                end
            end else if (b.opcode != OP_DOWN) begin
                r.point_status = ST_UNKNOWN;
            end else begin
                for (int s = SLOTS - 1; s >= 0; s--) begin
                    if (!busy[s]) hit = s;
                end
                if (hit < 0) begin
                    r.point_status = ST_FULL;
                end else begin
                    busy[hit] = 1'b1;
                    owner[hit] = b.contact_id;
                    r.point_status = ST_PLACED;
                    taken = 1'b1;
                end
            end
            if (taken) begin
                frame_hit = 1'b1;
                r.slot_index = SLOT_W'(hit);
                r.out_x = b.pos_x;
                r.out_y = b.pos_y;
            end
            r.frame_end = b.frame_last;
            r.frame_empty = b.frame_last && !frame_hit;
            if (b.frame_last) begin
                frame_hit = 1'b0;
                frames++;
                if (r.frame_empty) empty_frames++;
            end
            by_status[r.point_status]++;
            due = {due, r};
        endfunction

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) begin
                report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
            end
        endtask

        // compare one result beat with the oldest prediction
        task check(t_out_beat got);
            t_out_beat want;
            if (due.size() == 0) begin
                report("result beat with nothing outstanding");
            end else begin
                want = due.pop_front();
                results++;
                compare_field("slot_index", got.slot_index, want.slot_index);
                compare_field("point_status", got.point_status, want.point_status);
                compare_field("out_x", got.out_x, want.out_x);
                compare_field("out_y", got.out_y, want.out_y);
                compare_field("frame_end", got.frame_end, want.frame_end);
                compare_field("frame_empty", got.frame_empty, want.frame_empty);
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_data;

    int send_idle_pct = 37;
    int recv_idle_pct = 75;

    point_scoreboard sb = new();

    touch_id_slot_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result beat checking
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) sb.check(out_data);
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic t_in_beat point(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                       logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                       logic last);
        t_in_beat b;
        b.opcode = op;
        b.contact_id = id;
        b.pos_x = x;
        b.pos_y = y;
        b.frame_last = last;
        return b;
    endfunction

    // present one beat, with random idle cycles ahead of it
    task push_point(t_in_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge i_clk); while (!in_ready);
        sb.note(b);
    endtask

    // random point: a new or live contact, or a stray id, filling or draining the pool
    function automatic t_in_beat random_point(bit filling);
        t_in_beat        b;
        int              roll;
        logic [ID_W-1:0] live [$];
        for (int s = 0; s < SLOTS; s++) begin
            if (sb.busy[s]) live = {live, sb.owner[s]};
        end
        b.pos_x = POS_W'($urandom);
        b.pos_y = POS_W'($urandom);
        b.frame_last = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            // stray point, any action
            b.opcode = OP_W'($urandom_range(0, 3));
            b.contact_id = $urandom;
        end else if (live.size() == 0 || roll < (filling ? 60 : 25)) begin
            b.opcode = OP_DOWN;
            b.contact_id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom_range(0, 31))
                                                       : ID_W'($urandom);
        end else begin
            b.contact_id = live[$urandom_range(0, live.size() - 1)];
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 60 : 30)) begin
                b.opcode = OP_MOVE;
            end else if (roll < (filling ? 70 : 35)) begin
                b.opcode = OP_DOWN;
            end else if (roll < (filling ? 85 : 70)) begin
                b.opcode = OP_UP;
            end else begin
                b.opcode = OP_CANCEL;
            end
        end
        return b;
    endfunction

    // stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty frame, single contact life cycle, stray ids
        push_point(point(OP_MOVE, 32'hFFFF_FFFF, 16'h1234, 16'h5678, 1'b1));
        push_point(point(OP_DOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        push_point(point(OP_MOVE, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0));
        push_point(point(OP_DOWN, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555, 1'b0));
        push_point(point(OP_UP, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 1'b1));
        push_point(point(OP_UP, 32'h0000_0001, 16'h0001, 16'h8000, 1'b0));
        push_point(point(OP_CANCEL, 32'h0000_0000, 16'h8000, 16'h0001, 1'b1));

        // directed: fill every slot, overflow, then cancel one
        for (int k = 0; k < SLOTS; k++) begin
            push_point(point(OP_DOWN, ID_W'(k), POS_W'(1 << k), ~POS_W'(1 << k),
                             k == SLOTS - 1));
        end
        push_point(point(OP_DOWN, 32'h8000_0000, 16'h7FFF, 16'hFFFE, 1'b0));
        push_point(point(OP_CANCEL, 32'h0000_0000, 16'hFFFF, 16'h0000, 1'b1));

        // random phases with different idle patterns
        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = (p == 0) ? 37 : (p == 1) ? 75 : 0;
            recv_idle_pct = (p == 0) ? 75 : (p == 1) ? 37 : 0;
            for (int i = 0; i < RAND_POINTS / PHASES + 1; i++) begin
                push_point(random_point(((i / SWING_LEN) % 2) == 0));
            end
        end
        in_valid <= 1'b0;

        // drain and allow for stray beats
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d points checked over %0d frames, %0d of them empty",
                 sb.results, sb.frames, sb.empty_frames);
        $display("%0d placed, %0d updated, %0d released, %0d unknown id, %0d pool full",
                 sb.by_status[ST_PLACED], sb.by_status[ST_UPDATED],
                 sb.by_status[ST_RELEASED], sb.by_status[ST_UNKNOWN],
                 sb.by_status[ST_FULL]);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
